@@ rtl/kpi_pkg.sv @@
package kpi_pkg;

    // channel layout
    localparam int CHANNELS      = 9;
    localparam int CH_W          = 4;
    localparam int CH_ROT_FIRST  = 3;
    localparam int CH_ROT_LAST   = 5;
    localparam int CH_SCALE_FIRST = 6;

    // default sizes
    localparam int PARTS_DEFAULT   = 16;
    localparam int MOTIONS_DEFAULT = 8;
    localparam int KEYS_DEFAULT    = 8;

    // q16.16 constants
    localparam logic signed [33:0] PI_Q  = 34'sd205887;
    localparam logic signed [33:0] TAU_Q = 34'sd411775;
    localparam logic [31:0]        SCALE_ONE = 32'h0001_0000;

    // register defaults
    localparam logic [4:0] PART_COUNT_RESET = 5'd1;
    localparam logic [2:0] NEXT_MOTION_RESET = 3'd0;
    localparam logic [7:0] BLEND_RESET = 8'd10;

    // divider geometry
    localparam int DIFF_W    = 34;
    localparam int DIV_W     = 36;
    localparam int DIV_RADIX = 4;
    localparam int DIV_STEPS = DIV_W / DIV_RADIX;

    // operation codes
    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_SET_MOTION = 3'd1;
    localparam logic [2:0] OP_KEY_TARGET = 3'd2;
    localparam logic [2:0] OP_KEY_FRAMES = 3'd3;
    localparam logic [2:0] OP_MOTION_HDR = 3'd4;
    localparam logic [2:0] OP_BASE_POSE  = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [1:0] CFG_PART_COUNT  = 2'd0;
    localparam logic [1:0] CFG_NEXT_MOTION = 2'd1;
    localparam logic [1:0] CFG_BLEND       = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic [2:0]         motion_index;
        logic [2:0]         key_index;
        logic [3:0]         part_index;
        logic [3:0]         channel;
        logic signed [31:0] value;
        logic               loop_flag;
    } in_t;

    typedef struct packed {
        logic [3:0]         out_part;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic               last;
    } out_t;

    // per part and channel word
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] step;
        logic [31:0] base;
    } chan_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PART,
        ST_FRAMES,
        ST_CH_RD,
        ST_CH_EVAL,
        ST_DIV,
        ST_CH_WR,
        ST_EMIT,
        ST_NEXT,
        ST_BASE_RD,
        ST_BASE_WR
    } state_t;

endpackage

@@ rtl/kpi_divider.sv @@
module kpi_divider
    import kpi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dividend,
    input  logic [7:0]               divisor,
    output logic                     done,
    output logic signed [31:0]       quotient
);

    localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic [DIV_W-1:0] num_reg;
    logic [7:0]       rem_reg;
    logic [7:0]       den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;

    logic [DIV_W-1:0] num_step;
    logic [7:0]       rem_step;
    logic [DIV_W-1:0] start_mag;

    // radix-16 restoring step: four bits of quotient per cycle
    always_comb begin
        logic [DIV_W-1:0] n;
        logic [7:0]       r;
        logic [8:0]       t;
        n = num_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_RADIX; i++) begin
            t = {r, n[DIV_W-1]};
            n = {n[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t    = t - {1'b0, den_reg};
                n[0] = 1'b1;
            end
            r = t[7:0];
        end
        num_step = n;
        rem_step = r;
    end

    always_comb begin
        logic [DIV_W-1:0] sx;
        sx = {{(DIV_W-DIFF_W){dividend[DIFF_W-1]}}, dividend};
        start_mag = dividend[DIFF_W-1] ? (~sx + 1'b1) : sx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= start_mag;
                rem_reg  <= '0;
                den_reg  <= divisor;
                neg_reg  <= dividend[DIFF_W-1];
            end else if (busy_reg) begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // sign and saturate to 32 bits
    always_comb begin
        if (neg_reg) begin
            if (num_reg > DIV_W'(33'h0_8000_0000))
                quotient = 32'sh8000_0000;
            else
                quotient = -$signed(num_reg[31:0]);
        end else begin
            if (num_reg > DIV_W'(32'h7FFF_FFFF))
                quotient = 32'sh7FFF_FFFF;
            else
                quotient = $signed(num_reg[31:0]);
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/kpi_chan_ram.sv @@
module kpi_chan_ram
    import kpi_pkg::*;
#(
    parameter int DEPTH = PARTS_DEFAULT * CHANNELS
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output chan_word_t               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  chan_word_t               wr_data
);

    chan_word_t mem [DEPTH];
    chan_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/kpi_target_ram.sv @@
module kpi_target_ram
    import kpi_pkg::*;
#(
    parameter int DEPTH = MOTIONS_DEFAULT * KEYS_DEFAULT * PARTS_DEFAULT * CHANNELS
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/keyframe_pose_interpolator_core.sv @@
// channel   ports                               beat carries
// input     s_valid  s_ready  s_data (in_t)     one command: tick, set motion or table write
// result    m_valid  m_ready  m_data (out_t)    one part pose, last set on the final part
// config    cfg_valid cfg_ready cfg_index cfg_data  part_count, next_motion, blend_frames
//
// after reset a clearing pass writes every part and channel of the pose memory; no input until done
// table writes finish in idle; base pose writes are a read-modify-write of the pose word
// a tick walks every processed part through its channels; a part that moves to a new key also
//   runs nine divisions on the shared four-bits-per-cycle divider
// set motion runs the same divisions for each part that switches and passes over each part that stays
// one part is handled at a time; a stalled result port holds the sequencer at that part
module keyframe_pose_interpolator_core
    import kpi_pkg::*;
#(
    parameter int PARTS   = PARTS_DEFAULT,
    parameter int MOTIONS = MOTIONS_DEFAULT,
    parameter int KEYS    = KEYS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    localparam int PW   = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int PCW  = $clog2(PARTS + 1);
    localparam int MW   = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
    localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CAD  = PARTS * CHANNELS;
    localparam int CAW  = $clog2(CAD);
    localparam int TAD  = MOTIONS * KEYS * PARTS * CHANNELS;
    localparam int TAW  = $clog2(TAD);
    localparam int FAD  = MOTIONS * KEYS;
    localparam int FAW  = (FAD > 1) ? $clog2(FAD) : 1;

    // control state
    state_t           state_reg, state_next;
    logic [PCW-1:0]   p_reg;
    logic [CH_W-1:0]  c_reg;
    logic             tick_reg;
    logic             aim_reg;
    logic [MW-1:0]    m_reg;
    logic [KW-1:0]    k_reg;
    logic [MW-1:0]    m_sel_reg;
    logic [7:0]       frames_reg;
    logic [31:0]      step_reg;
    logic [31:0]      val_reg;
    chan_word_t       word_reg;
    logic [31:0]      pose_reg [CHANNELS];
    logic             m_valid_reg;
    out_t             m_data_reg;

    // configuration registers
    logic [4:0]       part_count_reg;
    logic [2:0]       next_motion_reg;
    logic [7:0]       blend_reg;

    // per part sequencing state and per motion header
    logic [MW-1:0]    mot_arr [PARTS];
    logic [KW-1:0]    key_arr [PARTS];
    logic [7:0]       cd_arr  [PARTS];
    logic [3:0]       mkc_arr [MOTIONS];
    logic             loop_arr [MOTIONS];

    // key frame count memory
    logic [7:0]       kfc_mem [FAD];
    logic [7:0]       kfc_q_reg;

    logic             s_fire;
    int               n_int;
    logic             last_part;
    logic [PW-1:0]    pidx;
    logic [CAW-1:0]   chan_addr;
    chan_word_t       chan_rd_data;
    chan_word_t       chan_wr_data;
    logic             chan_rd_en;
    logic             chan_wr_en;
    logic             tgt_rd_en;
    logic             tgt_wr_en;
    logic [TAW-1:0]   tgt_rd_addr;
    logic [TAW-1:0]   tgt_wr_addr;
    logic [31:0]      tgt_rd_data;
    logic             div_start;
    logic             div_done;
    logic signed [31:0] div_q;
    logic signed [DIFF_W-1:0] diff;
    logic [31:0]      off_new;
    logic             aim_now;
    logic [MW-1:0]    m_new;
    logic [KW-1:0]    k_new;
    logic [MW-1:0]    m_next_clamped;
    logic             tgt_in_range;
    logic             base_in_range;
    logic [7:0]       kfc_sat;
    logic [3:0]       mkc_sat;
    logic [7:0]       blend_frames_eff;

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign pidx      = p_reg[PW-1:0];

    // parts processed this command: part_count capped at PARTS
    assign n_int     = (int'(part_count_reg) > PARTS) ? PARTS : int'(part_count_reg);
    assign last_part = (int'(p_reg) + 1 == n_int);

    assign chan_addr = CAW'(int'(pidx) * CHANNELS + int'(c_reg));

    assign m_next_clamped = (int'(next_motion_reg) >= MOTIONS) ? MW'(MOTIONS - 1)
                                                                : MW'(next_motion_reg);
    assign blend_frames_eff = (blend_reg == 8'd0) ? 8'd1 : blend_reg;

    // table write range checks and saturation
    assign tgt_in_range  = (int'(s_data.motion_index) < MOTIONS) &&
                           (int'(s_data.key_index) < KEYS) &&
                           (int'(s_data.part_index) < PARTS) &&
                           (int'(s_data.channel) < CHANNELS);
    assign base_in_range = (int'(s_data.part_index) < PARTS) &&
                           (int'(s_data.channel) < CHANNELS);
    assign kfc_sat = s_data.value[31] ? 8'd0 :
                     ((s_data.value > 32'sd255) ? 8'd255 : s_data.value[7:0]);
    assign mkc_sat = s_data.value[31] ? 4'd0 :
                     ((s_data.value > 32'sd15) ? 4'd15 : s_data.value[3:0]);

    // decide whether the current part takes a new key, and which one
    always_comb begin
        logic [KW:0] k1;
        logic        wrap;
        k1      = {1'b0, key_arr[pidx]} + 1'b1;
        wrap    = (int'(k1) >= int'(mkc_arr[mot_arr[pidx]])) || (int'(k1) >= KEYS);
        aim_now = 1'b0;
        m_new   = mot_arr[pidx];
        k_new   = key_arr[pidx];
        if (tick_reg) begin
            aim_now = (cd_arr[pidx] <= 8'd1);
            if (wrap) begin
                k_new = '0;
                if (!loop_arr[mot_arr[pidx]])
                    m_new = m_next_clamped;
            end else begin
                k_new = k1[KW-1:0];
            end
        end else begin
            aim_now = (mot_arr[pidx] != m_sel_reg);
            m_new   = m_sel_reg;
            k_new   = '0;
        end
    end

    // target minus offset, rotation channels wrapped once into +-pi
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        d = {{2{tgt_rd_data[31]}}, tgt_rd_data}
          - {{2{chan_rd_data.offset[31]}}, chan_rd_data.offset};
        if (int'(c_reg) >= CH_ROT_FIRST && int'(c_reg) <= CH_ROT_LAST) begin
            if (d > PI_Q)
                d = d - TAU_Q;
            else if (d < -PI_Q)
                d = d + TAU_Q;
        end
        diff = d;
    end

    // offset moves by the step only on a tick
    assign off_new = tick_reg ? (word_reg.offset + step_reg) : word_reg.offset;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (int'(p_reg) == PARTS - 1 && int'(c_reg) == CHANNELS - 1)
                    state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if ((s_data.op == OP_TICK || s_data.op == OP_SET_MOTION) && n_int != 0)
                        state_next = ST_PART;
                    else if (s_data.op == OP_BASE_POSE && base_in_range)
                        state_next = ST_BASE_RD;
                end
            end
            ST_PART: begin
                if (aim_now)
                    state_next = ST_FRAMES;
                else if (tick_reg)
                    state_next = ST_CH_RD;
                else
                    state_next = ST_NEXT;
            end
            ST_FRAMES:  state_next = ST_CH_RD;
            ST_CH_RD:   state_next = ST_CH_EVAL;
            ST_CH_EVAL: state_next = aim_reg ? ST_DIV : ST_CH_WR;
            ST_DIV: begin
                if (div_done)
                    state_next = ST_CH_WR;
            end
            ST_CH_WR: begin
                if (int'(c_reg) == CHANNELS - 1)
                    state_next = tick_reg ? ST_EMIT : ST_NEXT;
                else
                    state_next = ST_CH_RD;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready)
                    state_next = ST_NEXT;
            end
            ST_NEXT:    state_next = last_part ? ST_IDLE : ST_PART;
            ST_BASE_RD: state_next = ST_BASE_WR;
            ST_BASE_WR: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        chan_rd_en   = (state_reg == ST_CH_RD) || (state_reg == ST_BASE_RD);
        chan_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_CH_WR) ||
                       (state_reg == ST_BASE_WR);
        chan_wr_data = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                chan_wr_data.base = (int'(c_reg) >= CH_SCALE_FIRST) ? SCALE_ONE : 32'd0;
            end
            ST_CH_WR: begin
                chan_wr_data.offset = off_new;
                chan_wr_data.step   = step_reg;
                chan_wr_data.base   = word_reg.base;
            end
            ST_BASE_WR: begin
                chan_wr_data.offset = chan_rd_data.offset;
                chan_wr_data.step   = chan_rd_data.step;
                chan_wr_data.base   = val_reg;
            end
            default: chan_wr_data = '0;
        endcase
        tgt_rd_en   = (state_reg == ST_CH_RD);
        tgt_rd_addr = TAW'(((int'(m_reg) * KEYS + int'(k_reg)) * PARTS + int'(pidx))
                           * CHANNELS + int'(c_reg));
        tgt_wr_en   = s_fire && (s_data.op == OP_KEY_TARGET) && tgt_in_range;
        tgt_wr_addr = TAW'(((int'(s_data.motion_index) * KEYS + int'(s_data.key_index))
                            * PARTS + int'(s_data.part_index)) * CHANNELS
                           + int'(s_data.channel));
        div_start   = (state_reg == ST_CH_EVAL) && aim_reg;
    end

    // key frame count memory
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.op == OP_KEY_FRAMES &&
            int'(s_data.motion_index) < MOTIONS && int'(s_data.key_index) < KEYS) begin
            kfc_mem[FAW'(int'(s_data.motion_index) * KEYS + int'(s_data.key_index))]
                <= kfc_sat;
        end
        if (state_reg == ST_PART) begin
            kfc_q_reg <= kfc_mem[FAW'(int'(m_new) * KEYS + int'(k_new))];
        end
    end

    // motion key counts, no reset: unknown until written
    always_ff @(posedge aclk) begin
        if (s_fire && s_data.op == OP_MOTION_HDR && int'(s_data.motion_index) < MOTIONS) begin
            mkc_arr[MW'(s_data.motion_index)] <= mkc_sat;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            p_reg           <= '0;
            c_reg           <= '0;
            m_valid_reg     <= 1'b0;
            part_count_reg  <= PART_COUNT_RESET;
            next_motion_reg <= NEXT_MOTION_RESET;
            blend_reg       <= BLEND_RESET;
            tick_reg        <= 1'b0;
            aim_reg         <= 1'b0;
            for (int i = 0; i < PARTS; i++) begin
                mot_arr[i] <= '0;
                key_arr[i] <= '0;
                cd_arr[i]  <= '0;
            end
            for (int i = 0; i < MOTIONS; i++) begin
                loop_arr[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PART_COUNT:  part_count_reg  <= cfg_data[4:0];
                    CFG_NEXT_MOTION: next_motion_reg <= cfg_data[2:0];
                    CFG_BLEND:       blend_reg       <= cfg_data;
                    default: ;
                endcase
            end

            // in the emit state the beat register is refilled instead
            if (m_valid_reg && m_ready && state_reg != ST_EMIT)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_CLEAR: begin
                    if (int'(c_reg) == CHANNELS - 1) begin
                        c_reg <= '0;
                        p_reg <= (int'(p_reg) == PARTS - 1) ? '0 : p_reg + 1'b1;
                    end else begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        tick_reg <= (s_data.op == OP_TICK);
                        m_sel_reg <= (int'(s_data.motion_index) >= MOTIONS) ?
                                     MW'(MOTIONS - 1) : MW'(s_data.motion_index);
                        val_reg  <= s_data.value;
                        if (s_data.op == OP_BASE_POSE) begin
                            p_reg <= PCW'(s_data.part_index);
                            c_reg <= CH_W'(s_data.channel);
                        end else begin
                            p_reg <= '0;
                            c_reg <= '0;
                        end
                        if (s_data.op == OP_MOTION_HDR && int'(s_data.motion_index) < MOTIONS)
                            loop_arr[MW'(s_data.motion_index)] <= s_data.loop_flag;
                    end
                end
                ST_PART: begin
                    aim_reg <= aim_now;
                    m_reg   <= m_new;
                    k_reg   <= k_new;
                    c_reg   <= '0;
                    if (aim_now) begin
                        mot_arr[pidx] <= m_new;
                        key_arr[pidx] <= k_new;
                    end else if (tick_reg) begin
                        cd_arr[pidx] <= cd_arr[pidx] - 1'b1;
                    end
                end
                ST_FRAMES: begin
                    // a zero frame count counts as one frame
                    if (tick_reg) begin
                        frames_reg    <= (kfc_q_reg == 8'd0) ? 8'd1 : kfc_q_reg;
                        cd_arr[pidx]  <= (kfc_q_reg == 8'd0) ? 8'd1 : kfc_q_reg;
                    end else begin
                        frames_reg    <= blend_frames_eff;
                        cd_arr[pidx]  <= blend_frames_eff;
                    end
                end
                ST_CH_EVAL: begin
                    word_reg <= chan_rd_data;
                    if (!aim_reg)
                        step_reg <= chan_rd_data.step;
                end
                ST_DIV: begin
                    if (div_done)
                        step_reg <= div_q;
                end
                ST_CH_WR: begin
                    pose_reg[c_reg] <= word_reg.base + off_new;
                    if (int'(c_reg) != CHANNELS - 1)
                        c_reg <= c_reg + 1'b1;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_data_reg.out_part <= 4'(p_reg);
                        m_data_reg.pos_x    <= pose_reg[0];
                        m_data_reg.pos_y    <= pose_reg[1];
                        m_data_reg.pos_z    <= pose_reg[2];
                        m_data_reg.rot_x    <= pose_reg[3];
                        m_data_reg.rot_y    <= pose_reg[4];
                        m_data_reg.rot_z    <= pose_reg[5];
                        m_data_reg.scale_x  <= pose_reg[6];
                        m_data_reg.scale_y  <= pose_reg[7];
                        m_data_reg.scale_z  <= pose_reg[8];
                        m_data_reg.last     <= last_part;
                    end
                end
                ST_NEXT: begin
                    if (!last_part)
                        p_reg <= p_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    kpi_chan_ram #(
        .DEPTH(CAD)
    ) u_chan_ram (
        .aclk    (aclk),
        .rd_en   (chan_rd_en),
        .rd_addr (chan_addr),
        .rd_data (chan_rd_data),
        .wr_en   (chan_wr_en),
        .wr_addr (chan_addr),
        .wr_data (chan_wr_data)
    );

    kpi_target_ram #(
        .DEPTH(TAD)
    ) u_target_ram (
        .aclk    (aclk),
        .rd_en   (tgt_rd_en),
        .rd_addr (tgt_rd_addr),
        .rd_data (tgt_rd_data),
        .wr_en   (tgt_wr_en),
        .wr_addr (tgt_wr_addr),
        .wr_data (s_data.value)
    );

    kpi_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff),
        .divisor  (frames_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // divider result only arrives while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside wait state");

    // a result beat is only built for a part inside the processed range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (int'(p_reg) < n_int))
        else $error("result for part beyond part count");

    // channel walk never runs past the last channel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CH_WR) |-> (int'(c_reg) < CHANNELS))
        else $error("channel index out of range");

    // only ticks produce result beats
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> tick_reg)
        else $error("result beat outside a tick");

endmodule

@@ test/pose_checker.sv @@
`timescale 1ns / 1ps

module pose_checker
    import kpi_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_t                  s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_t                 m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    output int                   errors,
    output int                   poses_waiting,
    output int                   poses_seen,
    output int                   ticks_seen
);

    localparam int NP = PARTS_DEFAULT;
    localparam int NM = MOTIONS_DEFAULT;
    localparam int NK = KEYS_DEFAULT;

    logic [4:0]  part_cnt;
    logic [2:0]  nxt_motion;
    logic [7:0]  blend;

    logic [2:0]  cur_motion [NP];
    logic [2:0]  cur_key    [NP];
    logic [7:0]  cdown      [NP];
    logic [31:0] offs       [NP][CHANNELS];
    logic [31:0] steps      [NP][CHANNELS];
    logic [31:0] basep      [NP][CHANNELS];
    logic [31:0] tgt        [NM][NK][NP][CHANNELS];
    logic [7:0]  kframes    [NM][NK];
    logic [3:0]  kcount     [NM];
    logic        loops      [NM];

    out_t pose_q[$];

    assign poses_waiting = pose_q.size();

    // aim a part at a key, setting the per-frame step of every channel
    function automatic void aim_part(int p, int m, int k, int fr);
        longint diff;
        longint stp;
        if (fr == 0) fr = 1;
        for (int c = 0; c < CHANNELS; c++) begin
            diff = longint'($signed(tgt[m][k][p][c])) - longint'($signed(offs[p][c]));
            if (c >= CH_ROT_FIRST && c <= CH_ROT_LAST) begin
                if (diff > longint'(PI_Q)) diff -= longint'(TAU_Q);
                else if (diff < -longint'(PI_Q)) diff += longint'(TAU_Q);
            end
            stp = diff / longint'(fr);
            if (stp > 64'sd2147483647) stp = 64'sd2147483647;
            if (stp < -64'sd2147483648) stp = -64'sd2147483648;
            steps[p][c] = stp[31:0];
        end
        cdown[p] = fr[7:0];
    endfunction

    function automatic void run_tick();
        int n;
        int m;
        int k;
        int lim;
        logic [31:0] v [CHANNELS];
        out_t e;
        n = (part_cnt > NP) ? NP : part_cnt;
        ticks_seen++;
        for (int p = 0; p < n; p++) begin
            if (cdown[p] <= 1) begin
                m = cur_motion[p];
                lim = (kcount[m] > NK) ? NK : kcount[m];
                k = cur_key[p] + 1;
                if (k >= lim) begin
                    k = 0;
                    if (!loops[m]) m = nxt_motion;
                end
                cur_motion[p] = m;
                cur_key[p] = k;
                aim_part(p, m, k, kframes[m][k]);
            end else begin
                cdown[p]--;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                offs[p][c] = offs[p][c] + steps[p][c];
                v[c] = basep[p][c] + offs[p][c];
            end
            e.out_part = p[3:0];
            e.pos_x = v[0];   e.pos_y = v[1];   e.pos_z = v[2];
            e.rot_x = v[3];   e.rot_y = v[4];   e.rot_z = v[5];
            e.scale_x = v[6]; e.scale_y = v[7]; e.scale_z = v[8];
            e.last = (p == n - 1);
            pose_q.push_back(e);
        end
    endfunction

    function automatic void apply_cmd(in_t d);
        int n;
        n = (part_cnt > NP) ? NP : part_cnt;
        case (d.op)
            OP_TICK: run_tick();
            OP_SET_MOTION: begin
                for (int p = 0; p < n; p++) begin
                    if (cur_motion[p] != d.motion_index) begin
                        cur_motion[p] = d.motion_index;
                        cur_key[p] = 0;
                        aim_part(p, d.motion_index, 0, blend);
                    end
                end
            end
            OP_KEY_TARGET: begin
                if (d.channel < CHANNELS)
                    tgt[d.motion_index][d.key_index][d.part_index][d.channel] = d.value;
            end
            OP_KEY_FRAMES: begin
                kframes[d.motion_index][d.key_index] =
                    (d.value < 0) ? 8'd0 : (d.value > 255) ? 8'd255 : d.value[7:0];
            end
            OP_MOTION_HDR: begin
                kcount[d.motion_index] =
                    (d.value < 0) ? 4'd0 : (d.value > 15) ? 4'd15 : d.value[3:0];
                loops[d.motion_index] = d.loop_flag;
            end
            OP_BASE_POSE: begin
                if (d.channel < CHANNELS) basep[d.part_index][d.channel] = d.value;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_pose(out_t got);
        out_t want;
        if (pose_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected pose beat, expected none, got part %0d",
                     $time, got.out_part);
            return;
        end
        want = pose_q.pop_front();
        poses_seen++;
        check_field("out_part", want.out_part, got.out_part);
        check_field("pos_x",    want.pos_x,    got.pos_x);
        check_field("pos_y",    want.pos_y,    got.pos_y);
        check_field("pos_z",    want.pos_z,    got.pos_z);
        check_field("rot_x",    want.rot_x,    got.rot_x);
        check_field("rot_y",    want.rot_y,    got.rot_y);
        check_field("rot_z",    want.rot_z,    got.rot_z);
        check_field("scale_x",  want.scale_x,  got.scale_x);
        check_field("scale_y",  want.scale_y,  got.scale_y);
        check_field("scale_z",  want.scale_z,  got.scale_z);
        check_field("last",     want.last,     got.last);
    endfunction

    initial begin
        errors = 0;
        poses_seen = 0;
        ticks_seen = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            part_cnt = PART_COUNT_RESET;
            nxt_motion = NEXT_MOTION_RESET;
            blend = BLEND_RESET;
            pose_q.delete();
            for (int p = 0; p < NP; p++) begin
                cur_motion[p] = 0;
                cur_key[p] = 0;
                cdown[p] = 0;
                for (int c = 0; c < CHANNELS; c++) begin
                    offs[p][c] = 0;
                    steps[p][c] = 0;
                    basep[p][c] = (c >= CH_SCALE_FIRST) ? SCALE_ONE : 32'd0;
                end
            end
            for (int m = 0; m < NM; m++) begin
                kcount[m] = 0;
                loops[m] = 0;
                for (int k = 0; k < NK; k++) begin
                    kframes[m][k] = 0;
                    for (int p = 0; p < NP; p++)
                        for (int c = 0; c < CHANNELS; c++) tgt[m][k][p][c] = 0;
                end
            end
        end else begin
            if (m_valid && m_ready) check_pose(m_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PART_COUNT:  part_cnt = cfg_data[4:0];
                    CFG_NEXT_MOTION: nxt_motion = cfg_data[2:0];
                    CFG_BLEND:       blend = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_cmd(s_data);
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import kpi_pkg::*;

    localparam int LIMIT  = 4_000_000;  // watchdog, cycles
    localparam int SETTLE = 2000;       // longest command with no pose beat, plus margin
    localparam int HOLD   = 3000;       // long receiver hold-off
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 8;
    localparam int LIVE_PARTS  = 8;     // parts whose targets are loaded

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    int errors, poses_waiting, poses_seen, ticks_seen;
    int cycles = 0;
    int beats_sent = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    // receiver side
    logic hold_go = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cycles = 0;
    int   win_left = 0;
    int   ready_pct = 100;

    always #4 aclk = ~aclk;

    keyframe_pose_interpolator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pose_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .poses_waiting(poses_waiting),
        .poses_seen(poses_seen), .ticks_seen(ticks_seen)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d poses outstanding", cycles, poses_waiting);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: one long hold-off on request, otherwise random stall windows
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD) hold_done = 1'b1;
        end else begin
            if (win_left == 0) begin
                win_left = 64;
                case ($urandom_range(0, 3))
                    0, 1:    ready_pct = 100;  // no stalls
                    2:       ready_pct = 60;
                    default: ready_pct = 20;
                endcase
            end
            win_left--;
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // motions 0 and 7 are the only ones parts ever enter; their tables are
    // loaded up front for the first LIVE_PARTS parts, and the part count never
    // goes above that, so no unwritten entry is ever read
    function automatic bit is_live(logic [2:0] m);
        return (m == 3'd0) || (m == 3'd7);
    endfunction

    // keys loaded per live motion
    function automatic int live_keys(logic [2:0] m);
        return (m == 3'd0) ? 1 : 2;
    endfunction

    function automatic in_t mk(logic [2:0] op, logic [2:0] mi, logic [2:0] ki,
                               logic [3:0] pi, logic [3:0] ch, logic [31:0] v, logic lf);
        in_t d;
        d.op = op;
        d.motion_index = mi;
        d.key_index = ki;
        d.part_index = pi;
        d.channel = ch;
        d.value = v;
        d.loop_flag = lf;
        return d;
    endfunction

    // mostly values near the rotation range, some full range, a few extremes
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 32'($urandom_range(0, 32'h000C_0000)) - 32'h0006_0000;
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic in_t random_cmd();
        in_t d;
        int r;
        d = mk(3'($urandom), 3'($urandom), 3'($urandom), 4'($urandom), 4'($urandom),
               $urandom, 1'($urandom));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            d.op = OP_TICK;
        end else if (r < 45) begin
            d.op = OP_SET_MOTION;
            d.motion_index = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        end else if (r < 65) begin
            d.op = OP_KEY_TARGET;
            d.value = pick_value();
        end else if (r < 75) begin
            d.op = OP_KEY_FRAMES;
            // live motions keep short keys so parts move often
            if (is_live(d.motion_index))
                d.value = ($urandom_range(0, 19) == 0) ? 32'd255 : $urandom_range(0, 6);
        end else if (r < 85) begin
            d.op = OP_MOTION_HDR;
            if (is_live(d.motion_index))
                d.value = ($urandom_range(0, 4) == 0) ? -$urandom_range(1, 1000)
                                                      : $urandom_range(0, live_keys(d.motion_index));
        end else if (r < 97) begin
            d.op = OP_BASE_POSE;
            d.value = pick_value();
        end else begin
            d.op = $urandom_range(0, 1) ? 3'd6 : 3'd7;  // unused ops, ignored
        end
        return d;
    endfunction

    // sender: bursts of random length separated by random gaps while gaps_on is set
    task automatic send_beat(input in_t d);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every pose, then for commands that produce none to finish
    task automatic drain();
        s_valid <= 1'b0;
        while (poses_waiting != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int pc_list [PHASES] = '{1, 0, 3, 8, 7, 2, 5, 1, 4};
        int nm_list [PHASES] = '{0, 7, 0, 7, 0, 7, 7, 0, 0};
        int bf_list [PHASES] = '{10, 1, 255, 0, 3, 2, 7, 1, 5};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // load the live motions: targets for the live parts, all frame counts, headers
        for (int p = 0; p < LIVE_PARTS; p++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                send_beat(mk(OP_KEY_TARGET, 3'd0, 3'd0, p[3:0], c[3:0], pick_value(), 1'b0));
                send_beat(mk(OP_KEY_TARGET, 3'd7, 3'd0, p[3:0], c[3:0], pick_value(), 1'b0));
                send_beat(mk(OP_KEY_TARGET, 3'd7, 3'd1, p[3:0], c[3:0], pick_value(), 1'b0));
            end
        end
        for (int k = 0; k < KEYS_DEFAULT; k++) begin
            send_beat(mk(OP_KEY_FRAMES, 3'd0, k[2:0], 4'd0, 4'd0, $urandom_range(0, 5), 1'b0));
            send_beat(mk(OP_KEY_FRAMES, 3'd7, k[2:0], 4'd0, 4'd0, $urandom_range(0, 5), 1'b0));
        end
        send_beat(mk(OP_MOTION_HDR, 3'd0, 3'd0, 4'd0, 4'd0, 32'd1, 1'b1));
        send_beat(mk(OP_MOTION_HDR, 3'd7, 3'd0, 4'd0, 4'd0, 32'd2, 1'b0));

        // directed: extremes, ignored writes, saturation, unused ops, zero frames
        send_beat(mk(OP_TICK, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        send_beat(mk(OP_SET_MOTION, 3'd7, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        send_beat(mk(OP_TICK, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        send_beat(mk(OP_SET_MOTION, 3'd7, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));  // already there
        send_beat(mk(OP_KEY_TARGET, 3'd7, 3'd1, 4'd0, 4'd3, 32'h7FFF_FFFF, 1'b0));
        send_beat(mk(OP_KEY_TARGET, 3'd7, 3'd1, 4'd0, 4'd4, 32'h8000_0000, 1'b0));
        send_beat(mk(OP_KEY_TARGET, 3'd7, 3'd1, 4'd0, 4'd9, 32'h1234_5678, 1'b0));
        send_beat(mk(OP_BASE_POSE, 3'd0, 3'd0, 4'd15, 4'd8, 32'h8000_0000, 1'b0));
        send_beat(mk(OP_BASE_POSE, 3'd0, 3'd0, 4'd0, 4'd15, 32'hFFFF_FFFF, 1'b0));
        send_beat(mk(OP_KEY_FRAMES, 3'd3, 3'd7, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0));
        send_beat(mk(OP_KEY_FRAMES, 3'd5, 3'd0, 4'd0, 4'd0, 32'd1000, 1'b0));
        send_beat(mk(OP_MOTION_HDR, 3'd6, 3'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1));
        send_beat(mk(OP_MOTION_HDR, 3'd2, 3'd0, 4'd0, 4'd0, -32'sd3, 1'b0));
        send_beat(mk(3'd6, 3'd7, 3'd7, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1));
        send_beat(mk(3'd7, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        for (int i = 0; i < 3; i++) send_beat(mk(OP_TICK, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        send_beat(mk(OP_SET_MOTION, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        send_beat(mk(OP_KEY_FRAMES, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        for (int i = 0; i < 3; i++) send_beat(mk(OP_TICK, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
        drain();

        // random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_PART_COUNT, pc_list[ph][7:0]);
            write_reg(CFG_NEXT_MOTION, nm_list[ph][7:0]);
            write_reg(CFG_BLEND, bf_list[ph][7:0]);
            gaps_on = (ph % 3 != 2);
            if (ph == 3) begin
                // long receiver hold-off with all live parts active
                hold_go <= 1'b1;
                send_beat(mk(OP_TICK, 3'd0, 3'd0, 4'd0, 4'd0, 32'd0, 1'b0));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) send_beat(random_cmd());
            drain();
        end

        $display("sent %0d command beats over %0d register settings", beats_sent, PHASES);
        $display("checked %0d pose beats from %0d ticks", poses_seen, ticks_seen);
        if (errors == 0 && poses_waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
